// ===== rtl/csim_pkg.sv =====
package csim_pkg;

    localparam int ELEM_W      = 16;
    localparam int PROD_W      = 2 * ELEM_W;
    localparam int DOT_W       = 42;
    localparam int SQ_W        = 41;
    localparam int NORM_W      = 29;
    localparam int COS_W       = 16;
    localparam int FRAC_SHIFT  = 16;
    localparam int RAD_W       = 2 * NORM_W;
    localparam int REM_W       = NORM_W + 2;
    localparam int HALF_W      = (NORM_W + 1) / 2;
    localparam int DEN_W       = 2 * NORM_W;
    localparam int QUO_W       = COS_W + 1;
    localparam int SQRT_STEPS  = NORM_W;
    localparam int DIV_STEPS   = DOT_W + 31;
    localparam int CNT_W       = $clog2(DIV_STEPS);

    typedef struct packed {
        logic signed [ELEM_W-1:0] elem_a;
        logic signed [ELEM_W-1:0] elem_b;
        logic                     last_element;
    } in_t;

    typedef struct packed {
        logic signed [DOT_W-1:0]  dot_product;
        logic        [NORM_W-1:0] norm_first;
        logic signed [COS_W-1:0]  cosine;
        logic                     zero_norm;
    } out_t;

    typedef struct packed {
        logic acc_en;
        logic acc_clr;
        logic root_load;
        logic root_step;
        logic mul_lo;
        logic mul_hi;
        logic mul_sum;
        logic div_load;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic zero_norm;
    } sts_t;

endpackage

// ===== rtl/csim_sqrt.sv =====
module csim_sqrt (
    input  logic                              aclk,
    input  logic                              load,
    input  logic                              step,
    input  logic [csim_pkg::RAD_W-1:0]        radicand,
    output logic [csim_pkg::NORM_W-1:0]       root
);

    logic [csim_pkg::RAD_W-1:0]  rad_reg, rad_next;
    logic [csim_pkg::REM_W-1:0]  rem_reg, rem_next;
    logic [csim_pkg::NORM_W-1:0] root_reg, root_next;
    logic [csim_pkg::REM_W+1:0]  trial_rem;
    logic [csim_pkg::REM_W+1:0]  trial_sub;

    // Two radicand bits enter the partial remainder per cycle while step is high; one root bit leaves.
    always_comb begin
        trial_rem = {rem_reg, rad_reg[csim_pkg::RAD_W-1 -: 2]};
        trial_sub = {1'b0, root_reg, 2'b01};
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (load) begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end else if (step) begin
            rad_next = {rad_reg[csim_pkg::RAD_W-3:0], 2'b00};
            if (trial_rem >= trial_sub) begin
                rem_next  = csim_pkg::REM_W'(trial_rem - trial_sub);
                root_next = {root_reg[csim_pkg::NORM_W-2:0], 1'b1};
            end else begin
                rem_next  = csim_pkg::REM_W'(trial_rem);
                root_next = {root_reg[csim_pkg::NORM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root = root_reg;

endmodule

// ===== rtl/csim_div.sv =====
module csim_div (
    input  logic                               aclk,
    input  logic                               load,
    input  logic                               step,
    input  logic signed [csim_pkg::DOT_W-1:0]  dividend,
    input  logic [csim_pkg::DEN_W-1:0]         divisor,
    output logic signed [csim_pkg::COS_W-1:0]  quotient
);

    logic [csim_pkg::DOT_W-1:0] num_reg, num_next;
    logic [csim_pkg::DEN_W-1:0] rem_reg, rem_next;
    logic [csim_pkg::QUO_W-1:0] quo_reg, quo_next;
    logic                       sat_reg, sat_next;
    logic                       neg_reg, neg_next;
    logic [csim_pkg::DEN_W:0]   trial_rem;
    logic                       quo_bit;
    logic [csim_pkg::QUO_W:0]   quo_shift;
    logic [csim_pkg::QUO_W-1:0] limit;

    // Restoring long division of the magnitude, shifted up by 31, one bit per cycle while step is high.
    // Once the quotient passes the Q1.15 limit it is pinned there for good.
    always_comb begin
        limit     = neg_reg ? csim_pkg::QUO_W'(32768) : csim_pkg::QUO_W'(32767);
        trial_rem = {rem_reg, num_reg[csim_pkg::DOT_W-1]};
        quo_bit   = (trial_rem >= {1'b0, divisor});
        quo_shift = {quo_reg, quo_bit};
        num_next  = num_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        sat_next  = sat_reg;
        neg_next  = neg_reg;
        if (load) begin
            neg_next = dividend[csim_pkg::DOT_W-1];
            num_next = dividend[csim_pkg::DOT_W-1] ? (~dividend + 1'b1) : dividend;
            rem_next = '0;
            quo_next = '0;
            sat_next = 1'b0;
        end else if (step && !sat_reg) begin
            num_next = {num_reg[csim_pkg::DOT_W-2:0], 1'b0};
            rem_next = quo_bit ? csim_pkg::DEN_W'(trial_rem - {1'b0, divisor})
                               : csim_pkg::DEN_W'(trial_rem);
            if (quo_shift > {1'b0, limit}) begin
                quo_next = limit;
                sat_next = 1'b1;
            end else begin
                quo_next = quo_shift[csim_pkg::QUO_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        sat_reg <= sat_next;
        neg_reg <= neg_next;
    end

    assign quotient = neg_reg ? csim_pkg::COS_W'(~quo_reg + 1'b1)
                              : csim_pkg::COS_W'(quo_reg);

endmodule

// ===== rtl/csim_dp.sv =====
module csim_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  csim_pkg::cmd_t       cmd,
    input  csim_pkg::in_t        s_data,
    output csim_pkg::sts_t       sts,
    output csim_pkg::out_t       m_data
);

    logic signed [csim_pkg::DOT_W-1:0] dot_sum_reg, dot_sum_next;
    logic [csim_pkg::SQ_W-1:0]         sq_first_reg, sq_first_next;
    logic [csim_pkg::SQ_W-1:0]         sq_second_reg, sq_second_next;
    logic signed [csim_pkg::PROD_W-1:0] prod_ab;
    logic signed [csim_pkg::PROD_W-1:0] prod_aa;
    logic signed [csim_pkg::PROD_W-1:0] prod_bb;

    logic [csim_pkg::NORM_W-1:0] norm_a;
    logic [csim_pkg::NORM_W-1:0] norm_b;

    logic [csim_pkg::NORM_W+csim_pkg::HALF_W-1:0] part_lo_reg;
    logic [csim_pkg::NORM_W+csim_pkg::HALF_W-1:0] part_hi_reg;
    logic [csim_pkg::DEN_W-1:0]                   den_reg;

    logic signed [csim_pkg::COS_W-1:0] cos_val;
    csim_pkg::out_t                    out_reg;

    assign prod_ab = s_data.elem_a * s_data.elem_b;
    assign prod_aa = s_data.elem_a * s_data.elem_a;
    assign prod_bb = s_data.elem_b * s_data.elem_b;

    always_comb begin
        dot_sum_next   = dot_sum_reg;
        sq_first_next  = sq_first_reg;
        sq_second_next = sq_second_reg;
        if (cmd.acc_clr) begin
            dot_sum_next   = '0;
            sq_first_next  = '0;
            sq_second_next = '0;
        end else if (cmd.acc_en) begin
            dot_sum_next   = dot_sum_reg + csim_pkg::DOT_W'(prod_ab);
            sq_first_next  = sq_first_reg
                           + {{(csim_pkg::SQ_W-csim_pkg::PROD_W){1'b0}}, prod_aa};
            sq_second_next = sq_second_reg
                           + {{(csim_pkg::SQ_W-csim_pkg::PROD_W){1'b0}}, prod_bb};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_sum_reg   <= '0;
            sq_first_reg  <= '0;
            sq_second_reg <= '0;
        end else begin
            dot_sum_reg   <= dot_sum_next;
            sq_first_reg  <= sq_first_next;
            sq_second_reg <= sq_second_next;
        end
    end

    assign sts.zero_norm = (sq_first_reg == '0) || (sq_second_reg == '0);

    csim_sqrt u_sqrt_a (
        .aclk     (aclk),
        .load     (cmd.root_load),
        .step     (cmd.root_step),
        .radicand ({1'b0, sq_first_reg, {csim_pkg::FRAC_SHIFT{1'b0}}}),
        .root     (norm_a)
    );

    csim_sqrt u_sqrt_b (
        .aclk     (aclk),
        .load     (cmd.root_load),
        .step     (cmd.root_step),
        .radicand ({1'b0, sq_second_reg, {csim_pkg::FRAC_SHIFT{1'b0}}}),
        .root     (norm_b)
    );

    // The product of the two norms is built from two half-width partial products.
    always_ff @(posedge aclk) begin
        if (cmd.mul_lo) begin
            part_lo_reg <= norm_a * norm_b[csim_pkg::HALF_W-1:0];
        end
        if (cmd.mul_hi) begin
            part_hi_reg <= norm_a
                         * {1'b0, norm_b[csim_pkg::NORM_W-1:csim_pkg::HALF_W]};
        end
        if (cmd.mul_sum) begin
            den_reg <= csim_pkg::DEN_W'(part_lo_reg)
                     + csim_pkg::DEN_W'({part_hi_reg, {csim_pkg::HALF_W{1'b0}}});
        end
    end

    csim_div u_div (
        .aclk     (aclk),
        .load     (cmd.div_load),
        .step     (cmd.div_step),
        .dividend (dot_sum_reg),
        .divisor  (den_reg),
        .quotient (cos_val)
    );

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.dot_product <= dot_sum_reg;
            out_reg.norm_first  <= norm_a;
            out_reg.cosine      <= sts.zero_norm ? '0 : cos_val;
            out_reg.zero_norm   <= sts.zero_norm;
        end
    end

    assign m_data = out_reg;

endmodule

// ===== rtl/csim_ctrl.sv =====
module csim_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_last,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  csim_pkg::sts_t       sts,
    output csim_pkg::cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_LOAD,
        ST_ROOT,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_SUM,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t                     state_reg;
    logic [csim_pkg::CNT_W-1:0] cnt_reg;
    logic                       m_valid_reg;
    logic                       accept;
    logic                       out_free;

    assign s_ready  = (state_reg == ST_ACCUM);
    assign m_valid  = m_valid_reg;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        cmd           = '0;
        cmd.acc_en    = accept;
        cmd.root_load = (state_reg == ST_LOAD);
        cmd.root_step = (state_reg == ST_ROOT);
        cmd.mul_lo    = (state_reg == ST_MUL_LO);
        cmd.mul_hi    = (state_reg == ST_MUL_HI);
        cmd.mul_sum   = (state_reg == ST_MUL_SUM);
        cmd.div_load  = (state_reg == ST_MUL_SUM);
        cmd.div_step  = (state_reg == ST_DIV);
        cmd.out_load  = (state_reg == ST_FINISH) && out_free;
        cmd.acc_clr   = cmd.out_load;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ACCUM;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_FINISH && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_ACCUM: begin
                    if (accept && s_last) begin
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    cnt_reg   <= '0;
                    state_reg <= ST_ROOT;
                end
                ST_ROOT: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == csim_pkg::CNT_W'(csim_pkg::SQRT_STEPS - 1)) begin
                        state_reg <= ST_MUL_LO;
                    end
                end
                ST_MUL_LO: begin
                    state_reg <= ST_MUL_HI;
                end
                ST_MUL_HI: begin
                    state_reg <= ST_MUL_SUM;
                end
                ST_MUL_SUM: begin
                    cnt_reg   <= '0;
                    // With a zero norm the cosine is forced to zero, so no division runs.
                    state_reg <= sts.zero_norm ? ST_FINISH : ST_DIV;
                end
                ST_DIV: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == csim_pkg::CNT_W'(csim_pkg::DIV_STEPS - 1)) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        state_reg <= ST_ACCUM;
                    end
                end
                default: begin
                    state_reg <= ST_ACCUM;
                end
            endcase
        end
    end

endmodule

// ===== rtl/cosine_similarity_engine.sv =====
// Channel | Ports                      | Request carries
// input   | s_valid, s_ready, s_data   | one element pair and the last-element mark
// result  | m_valid, m_ready, m_data   | dot product, first norm, cosine, zero-norm flag
//
// Element pairs are accumulated at one request per cycle until the last one arrives.
// After the last pair the input is held off while the two square roots are loaded and
// run side by side, the norm product is formed from its low and high partial products
// and their sum, and the cosine divider runs one quotient bit per cycle (skipped when a
// norm is zero); only then can the next vector start. The result sits in an output
// register; a stalled result only holds the next vector back in its finishing state.
// Reset is synchronous and active low and clears the sums and the controller.
module cosine_similarity_engine (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  csim_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output csim_pkg::out_t  m_data
);

    csim_pkg::cmd_t cmd;
    csim_pkg::sts_t sts;

    csim_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_data.last_element),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    csim_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_data  (s_data),
        .sts     (sts),
        .m_data  (m_data)
    );

endmodule

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT    = 4000;
    localparam int TAIL_CYCLES    = 150;
    localparam int IDLE_PCT       = 37;
    localparam int TOTAL_REQUESTS = 1800;

    typedef enum int {FILL_WIDE, FILL_EDGE, FILL_NARROW, FILL_ZERO} fill_t;
    typedef enum int {PAIR_FREE, PAIR_SAME, PAIR_OPPOSITE} pair_kind_t;

    logic           aclk    = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    csim_pkg::in_t  s_data  = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    csim_pkg::out_t m_data;

    bit steady_flow = 1'b0;

    // Running sums as the block should hold them, and the results still owed.
    logic [csim_pkg::DOT_W-1:0] run_dot  = '0;
    logic [csim_pkg::SQ_W-1:0]  run_sq_a = '0;
    logic [csim_pkg::SQ_W-1:0]  run_sq_b = '0;
    csim_pkg::out_t             due_similarity[$];

    int requests_sent   = 0;
    int vectors_sent    = 0;
    int results_checked = 0;
    int zero_norm_seen  = 0;
    int saturated_seen  = 0;
    int mismatch_count  = 0;
    int stall_cycles    = 0;

    cosine_similarity_engine u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5ns aclk = 1'b1;
        #5ns aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= steady_flow ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] probe;
        rem   = x;
        root  = '0;
        probe = 64'h1 << 62;
        while (probe > rem) probe = probe >> 2;
        while (probe != 0) begin
            if (rem >= root + probe) begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // Restoring division of |dot| * 2^31 by the norm product, one quotient bit per
    // step, stopping as soon as the quotient passes the Q1.15 limit for its sign.
    function automatic logic [csim_pkg::COS_W-1:0] q15_ratio(
        input logic [csim_pkg::DOT_W-1:0] dot,
        input logic [63:0]                den);
        logic                       neg;
        logic [csim_pkg::DOT_W-1:0] mag;
        logic [63:0]                ceiling;
        logic [63:0]                quo;
        logic [63:0]                part;
        logic                       next_bit;
        logic                       done;
        neg     = dot[csim_pkg::DOT_W-1];
        mag     = neg ? -dot : dot;
        ceiling = neg ? 64'd32768 : 64'd32767;
        quo     = '0;
        part    = '0;
        done    = 1'b0;
        for (int i = 0; i < csim_pkg::DOT_W + 31 && !done; i++) begin
            if (i < csim_pkg::DOT_W) begin
                next_bit = mag[csim_pkg::DOT_W-1-i];
            end else begin
                next_bit = 1'b0;
            end
            part = (part << 1) | 64'(next_bit);
            quo  = quo << 1;
            if (part >= den) begin
                part = part - den;
                quo  = quo | 64'd1;
            end
            if (quo > ceiling) begin
                quo  = ceiling;
                done = 1'b1;
            end
        end
        return neg ? csim_pkg::COS_W'(-quo) : csim_pkg::COS_W'(quo);
    endfunction

    task automatic fold_pair(input csim_pkg::in_t req);
        logic signed [csim_pkg::PROD_W-1:0] ab_prod;
        logic signed [csim_pkg::PROD_W-1:0] sq_a;
        logic signed [csim_pkg::PROD_W-1:0] sq_b;
        logic [63:0]                        root_a;
        logic [63:0]                        root_b;
        csim_pkg::out_t                     want;
        ab_prod  = $signed(req.elem_a) * $signed(req.elem_b);
        sq_a     = $signed(req.elem_a) * $signed(req.elem_a);
        sq_b     = $signed(req.elem_b) * $signed(req.elem_b);
        run_dot  = run_dot
                 + {{(csim_pkg::DOT_W-csim_pkg::PROD_W){ab_prod[csim_pkg::PROD_W-1]}},
                    ab_prod};
        run_sq_a = run_sq_a + {{(csim_pkg::SQ_W-csim_pkg::PROD_W){1'b0}}, sq_a};
        run_sq_b = run_sq_b + {{(csim_pkg::SQ_W-csim_pkg::PROD_W){1'b0}}, sq_b};
        if (req.last_element) begin
            root_a           = int_sqrt(64'({run_sq_a, {csim_pkg::FRAC_SHIFT{1'b0}}}));
            root_b           = int_sqrt(64'({run_sq_b, {csim_pkg::FRAC_SHIFT{1'b0}}}));
            want.zero_norm   = (run_sq_a == 0) || (run_sq_b == 0);
            want.cosine      = want.zero_norm ? '0 : q15_ratio(run_dot, root_a * root_b);
            want.dot_product = run_dot;
            want.norm_first  = root_a[csim_pkg::NORM_W-1:0];
            due_similarity.push_back(want);
            run_dot  = '0;
            run_sq_a = '0;
            run_sq_b = '0;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_result(input csim_pkg::out_t got);
        csim_pkg::out_t want;
        if (due_similarity.size() == 0) begin
            report_mismatch($sformatf("result with no request pending, dot %0d",
                                      got.dot_product));
        end else begin
            want = due_similarity.pop_front();
            results_checked++;
            if (want.zero_norm) zero_norm_seen++;
            else if (want.cosine == 16'sh7fff || want.cosine == 16'sh8000) saturated_seen++;
            if (got.dot_product !== want.dot_product)
                report_mismatch($sformatf("dot_product got %0d want %0d",
                                          got.dot_product, want.dot_product));
            if (got.norm_first !== want.norm_first)
                report_mismatch($sformatf("norm_first got %0d want %0d",
                                          got.norm_first, want.norm_first));
            if (got.cosine !== want.cosine)
                report_mismatch($sformatf("cosine got %0d want %0d",
                                          got.cosine, want.cosine));
            if (got.zero_norm !== want.zero_norm)
                report_mismatch($sformatf("zero_norm got %0b want %0b",
                                          got.zero_norm, want.zero_norm));
        end
    endtask

    // The request is folded in before the result is checked, so a result
    // always meets the oldest outstanding expectation.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) fold_pair(s_data);
            if (m_valid && m_ready) check_result(m_data);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // Called at a rising edge; returns at the edge where the request is taken,
    // with valid still high so a following request can go out without a gap.
    task automatic send_pair(input logic signed [csim_pkg::ELEM_W-1:0] a,
                             input logic signed [csim_pkg::ELEM_W-1:0] b,
                             input logic last);
        int            gap;
        csim_pkg::in_t req;
        gap = 0;
        if (!steady_flow) begin
            while ($urandom_range(99) < IDLE_PCT) gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        req.elem_a       = a;
        req.elem_b       = b;
        req.last_element = last;
        s_data  <= req;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        requests_sent++;
        if (last) vectors_sent++;
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (due_similarity.size() != 0);
        @(posedge aclk);
    endtask

    function automatic logic signed [csim_pkg::ELEM_W-1:0] pick_element(input fill_t fill);
        logic signed [csim_pkg::ELEM_W-1:0] v;
        case (fill)
            FILL_WIDE: begin
                v = csim_pkg::ELEM_W'($urandom);
            end
            FILL_EDGE: begin
                case ($urandom_range(4))
                    0:       v = 16'sh8000;
                    1:       v = 16'sh7fff;
                    2:       v = -16'sd1;
                    3:       v = 16'sd0;
                    default: v = 16'sd1;
                endcase
            end
            FILL_NARROW: begin
                v = csim_pkg::ELEM_W'(int'($urandom_range(16)) - 8);
            end
            default: begin
                v = '0;
            end
        endcase
        return v;
    endfunction

    function automatic fill_t pick_fill();
        int r;
        r = $urandom_range(15);
        if (r == 0) return FILL_ZERO;
        if (r < 4)  return FILL_EDGE;
        if (r < 8)  return FILL_NARROW;
        return FILL_WIDE;
    endfunction

    task automatic send_vector(input int length);
        logic signed [csim_pkg::ELEM_W-1:0] a;
        logic signed [csim_pkg::ELEM_W-1:0] b;
        pair_kind_t                         kind;
        fill_t                              fill_a;
        fill_t                              fill_b;
        int                                 r;
        r      = $urandom_range(9);
        kind   = (r < 6) ? PAIR_FREE : (r < 8) ? PAIR_SAME : PAIR_OPPOSITE;
        fill_a = pick_fill();
        fill_b = pick_fill();
        for (int i = 0; i < length; i++) begin
            a = pick_element(fill_a);
            case (kind)
                PAIR_SAME:     b = a;
                PAIR_OPPOSITE: b = -a;
                default:       b = pick_element(fill_b);
            endcase
            send_pair(a, b, i == length - 1);
        end
    endtask

    function automatic int pick_length();
        if ($urandom_range(9) == 0) return $urandom_range(200, 25);
        return $urandom_range(24, 1);
    endfunction

    task automatic test_directed_extremes();
        // Single pairs at the corners: cosine of +1 saturates, -1 is exact.
        send_pair(16'sh7fff, 16'sh7fff, 1'b1);
        send_pair(16'sh8000, 16'sh8000, 1'b1);
        send_pair(16'sh7fff, 16'sh8000, 1'b1);
        send_pair(16'sh8000, 16'sh7fff, 1'b1);
        // Zero norm on either side and on both.
        send_pair(16'sd0, 16'sd5, 1'b1);
        send_pair(16'sd5, 16'sd0, 1'b1);
        send_pair(16'sd0, 16'sd0, 1'b1);
        // Orthogonal vectors give a cosine of zero without the flag.
        send_pair(16'sd1, 16'sd0, 1'b0);
        send_pair(16'sd0, 16'sd1, 1'b1);
        // Truncated norms push the magnitude past one on both sides.
        send_pair(16'sd1, -16'sd1, 1'b0);
        send_pair(16'sd1, -16'sd1, 1'b1);
        send_pair(16'sd1, 16'sd1, 1'b0);
        send_pair(16'sd1, 16'sd1, 1'b1);
        send_pair(16'sd100, 16'sd200, 1'b0);
        send_pair(-16'sd50, 16'sd300, 1'b0);
        send_pair(16'sd7, -16'sd9, 1'b1);
    endtask

    // The sender holds off until the block has delivered every result.
    task automatic test_drain_pause();
        repeat (4) send_vector(pick_length());
        wait_for_results();
        repeat (4) send_vector(pick_length());
    endtask

    task automatic test_steady_flow();
        int stop_at;
        stop_at     = requests_sent + 300;
        steady_flow = 1'b1;
        while (requests_sent < stop_at) send_vector(pick_length());
        steady_flow = 1'b0;
    endtask

    // A full-length vector of maximal squares drives the square sums up to their top
    // bit, so the first norm reaches bit 28 and the cosine saturates.
    task automatic test_full_length();
        repeat (1023) send_pair(16'sh8000, 16'sh8000, 1'b0);
        send_pair(16'sh8000, 16'sh8000, 1'b1);
    endtask

    task automatic test_random_vectors();
        while (requests_sent < TOTAL_REQUESTS) send_vector(pick_length());
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_extremes();
        test_drain_pause();
        test_steady_flow();
        test_full_length();
        test_random_vectors();
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("covered %0d requests in %0d vectors, %0d results checked",
                 requests_sent, vectors_sent, results_checked);
        $display("%0d zero-norm results, %0d saturated cosines, %0d mismatches",
                 zero_norm_seen, saturated_seen, mismatch_count);
        if (mismatch_count == 0 && due_similarity.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
